// ===== design/chol_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cholesky factorization package
// Shared types and fixed widths for the controller, datapath and top level.
// ----------------------------------------------------------------------------
`default_nettype none

package chol_pkg;

    // Fixed widths of the external fields.
    localparam int DATA_W = 32;
    localparam int CFG_W  = 4;
    localparam int POS_W  = 3;

    // Controller states.
    typedef enum logic [3:0] {
        ST_LOAD,
        ST_ELEM,
        ST_MAC_RD,
        ST_MAC_MUL,
        ST_MAC_ACC,
        ST_FETCH,
        ST_RESOLVE,
        ST_BUSY,
        ST_WRITE,
        ST_OUT_RD,
        ST_OUT_LOAD,
        ST_OUT_WAIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic a_we;
        logic acc_clear;
        logic mul_en;
        logic acc_add;
        logic op_start;
        logic op_diag;
        logic l_we;
        logic err_clear;
        logic out_load;
        logic out_zero;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic op_done;
    } stat_t;

endpackage

`default_nettype wire

// ===== design/chol_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module chol_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

// ===== design/chol_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cholesky controller
// Sequences loading, the per-element factor computation and the output sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module chol_ctrl #(
    parameter int MAX_ORDER = 8,
    parameter int IDX_W     = 3
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    input  wire logic                       cfg_we,
    input  wire logic [chol_pkg::CFG_W-1:0] cfg_wdata,
    input  wire chol_pkg::stat_t            stat,
    output chol_pkg::cmd_t                  cmd,
    output logic [2*IDX_W-1:0]              a_waddr,
    output logic [2*IDX_W-1:0]              a_raddr,
    output logic [2*IDX_W-1:0]              l_raddr0,
    output logic [2*IDX_W-1:0]              l_raddr1,
    output logic [2*IDX_W-1:0]              l_waddr,
    output logic [chol_pkg::POS_W-1:0]      row_index,
    output logic [chol_pkg::POS_W-1:0]      column_index,
    output logic                            last_of_run
);

    import chol_pkg::*;

    state_t            state_reg, state_next;
    logic [CFG_W-1:0]  size_reg, size_next;
    logic [IDX_W-1:0]  i_reg, i_next;
    logic [IDX_W-1:0]  j_reg, j_next;
    logic [IDX_W-1:0]  k_reg, k_next;
    logic [CFG_W-1:0]  n_eff;
    logic [IDX_W-1:0]  nm1;
    logic [IDX_W-1:0]  jm1;
    logic              in_acc;
    logic              out_acc;
    logic              at_last;

    // Effective order, clamped into 1..MAX_ORDER.
    always_comb
    begin
        if (size_reg == '0)
        begin
            n_eff = CFG_W'(1);
        end
        else if (size_reg > CFG_W'(MAX_ORDER))
        begin
            n_eff = CFG_W'(MAX_ORDER);
        end
        else
        begin
            n_eff = size_reg;
        end
    end

    assign nm1     = IDX_W'(n_eff - CFG_W'(1));
    assign jm1     = j_reg - IDX_W'(1);
    assign at_last = (i_reg == nm1) && (j_reg == nm1);
    assign in_acc  = (state_reg == ST_LOAD) && in_valid;
    assign out_acc = (state_reg == ST_OUT_WAIT) && !out_stall;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:     if (in_acc && at_last) state_next = ST_ELEM;
            ST_ELEM:     state_next = (j_reg == '0) ? ST_FETCH : ST_MAC_RD;
            ST_MAC_RD:   state_next = ST_MAC_MUL;
            ST_MAC_MUL:  state_next = ST_MAC_ACC;
            ST_MAC_ACC:  state_next = (k_reg == jm1) ? ST_FETCH : ST_MAC_RD;
            ST_FETCH:    state_next = ST_RESOLVE;
            ST_RESOLVE:  state_next = ST_BUSY;
            ST_BUSY:     if (stat.op_done) state_next = ST_WRITE;
            ST_WRITE:
            begin
                if ((j_reg == i_reg) && (i_reg == nm1))
                begin
                    state_next = ST_OUT_RD;
                end
                else
                begin
                    state_next = ST_ELEM;
                end
            end
            ST_OUT_RD:   state_next = ST_OUT_LOAD;
            ST_OUT_LOAD: state_next = ST_OUT_WAIT;
            ST_OUT_WAIT: if (out_acc) state_next = at_last ? ST_LOAD : ST_OUT_RD;
            default:     state_next = ST_LOAD;
        endcase
    end

    // Commands and addresses.
    always_comb
    begin
        cmd          = '0;
        cmd.op_diag  = (i_reg == j_reg);
        cmd.out_zero = (j_reg > i_reg);
        a_waddr      = {i_reg, j_reg};
        a_raddr      = {j_reg, i_reg};
        l_raddr0     = {j_reg, k_reg};
        l_raddr1     = {i_reg, k_reg};
        l_waddr      = {i_reg, j_reg};
        in_stall     = (state_reg != ST_LOAD);
        out_valid    = (state_reg == ST_OUT_WAIT);
        case (state_reg)
            ST_LOAD:
            begin
                cmd.a_we      = in_acc;
                cmd.err_clear = in_acc && at_last;
            end
            ST_ELEM:     cmd.acc_clear = 1'b1;
            ST_MAC_MUL:  cmd.mul_en = 1'b1;
            ST_MAC_ACC:  cmd.acc_add = 1'b1;
            ST_FETCH:    l_raddr0 = {j_reg, j_reg};
            ST_RESOLVE:  cmd.op_start = 1'b1;
            ST_WRITE:    cmd.l_we = 1'b1;
            ST_OUT_RD:   l_raddr0 = {i_reg, j_reg};
            ST_OUT_LOAD: cmd.out_load = 1'b1;
            default:     cmd.a_we = 1'b0;
        endcase
    end

    // Loop counters.
    always_comb
    begin
        i_next    = i_reg;
        j_next    = j_reg;
        k_next    = k_reg;
        size_next = size_reg;
        if (cfg_we)
        begin
            size_next = cfg_wdata;
            i_next    = '0;
            j_next    = '0;
        end
        else if (in_acc || out_acc)
        begin
            // Row-major walk over the N by N matrix.
            if (j_reg == nm1)
            begin
                j_next = '0;
                i_next = (i_reg == nm1) ? '0 : i_reg + IDX_W'(1);
            end
            else
            begin
                j_next = j_reg + IDX_W'(1);
            end
        end
        else if (state_reg == ST_WRITE)
        begin
            // Walk over the lower triangle including the diagonal.
            if (j_reg == i_reg)
            begin
                j_next = '0;
                i_next = (i_reg == nm1) ? '0 : i_reg + IDX_W'(1);
            end
            else
            begin
                j_next = j_reg + IDX_W'(1);
            end
        end
        if (state_reg == ST_ELEM)
        begin
            k_next = '0;
        end
        else if (state_reg == ST_MAC_ACC)
        begin
            k_next = k_reg + IDX_W'(1);
        end
    end

    // Registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            size_reg  <= CFG_W'(MAX_ORDER);
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            size_reg  <= size_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    assign row_index    = POS_W'(i_reg);
    assign column_index = POS_W'(j_reg);
    assign last_of_run  = at_last;

endmodule

`default_nettype wire

// ===== design/chol_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cholesky datapath
// Matrix and factor stores, multiply-accumulate, bit-serial divider and
// bit-serial square root.
// ----------------------------------------------------------------------------
`default_nettype none

module chol_dp #(
    parameter int FRAC_BITS = 16,
    parameter int IDX_W     = 3
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire chol_pkg::cmd_t              cmd,
    input  wire logic [2*IDX_W-1:0]          a_waddr,
    input  wire logic [2*IDX_W-1:0]          a_raddr,
    input  wire logic [2*IDX_W-1:0]          l_raddr0,
    input  wire logic [2*IDX_W-1:0]          l_raddr1,
    input  wire logic [2*IDX_W-1:0]          l_waddr,
    input  wire logic [chol_pkg::DATA_W-1:0] matrix_entry,
    output chol_pkg::stat_t                  stat,
    output logic [chol_pkg::DATA_W-1:0]      factor_entry,
    output logic                             not_positive_definite
);

    import chol_pkg::*;

    localparam int DEPTH   = 2 ** (2 * IDX_W);
    localparam int NUM_W   = DATA_W + FRAC_BITS;
    localparam int SQ_STEP = 32;
    localparam int CNT_W   = $clog2(NUM_W + 1);

    logic [DATA_W-1:0]        a_rdata, l_rdata0, l_rdata1, l_wdata;
    logic signed [63:0]       acc_reg, prod_reg, a_ext, diff;
    logic [DATA_W-1:0]        d32, dmag, dvmag, out_reg;
    logic                     diag_pos, dv_zero;
    logic [30:0]              rad_clamp;
    logic [32:0]              rem_reg, shifted;
    logic [33:0]              trial;
    logic [NUM_W-1:0]         quo_reg;
    logic [DATA_W-1:0]        den_reg;
    logic [63:0]              v_reg, res_reg, bit_reg, sq_sum;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     busy_reg, diag_reg, zero_reg, neg_reg, err_reg;

    // Input matrix store and two mirrored copies of the factor store.
    chol_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_a_ram (
        .clk(clk), .we(cmd.a_we), .waddr(a_waddr), .wdata(matrix_entry),
        .raddr(a_raddr), .rdata(a_rdata)
    );

    chol_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_l_ram0 (
        .clk(clk), .we(cmd.l_we), .waddr(l_waddr), .wdata(l_wdata),
        .raddr(l_raddr0), .rdata(l_rdata0)
    );

    chol_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_l_ram1 (
        .clk(clk), .we(cmd.l_we), .waddr(l_waddr), .wdata(l_wdata),
        .raddr(l_raddr1), .rdata(l_rdata1)
    );

    // Operand preparation for the divide or square-root step.
    assign a_ext    = {{(64 - DATA_W){a_rdata[DATA_W-1]}}, a_rdata};
    assign diff     = a_ext - acc_reg;
    assign diag_pos = !diff[63] && (diff != '0);
    assign rad_clamp = (diff > 64'sh7FFF_FFFF) ? 31'h7FFF_FFFF : diff[30:0];

    always_comb
    begin
        if (diff > 64'sh7FFF_FFFF)
        begin
            d32 = 32'h7FFF_FFFF;
        end
        else if (diff < -64'sh8000_0000)
        begin
            d32 = 32'h8000_0000;
        end
        else
        begin
            d32 = diff[DATA_W-1:0];
        end
    end

    assign dmag    = d32[DATA_W-1] ? (~d32 + 32'd1) : d32;
    assign dvmag   = l_rdata0[DATA_W-1] ? (~l_rdata0 + 32'd1) : l_rdata0;
    assign dv_zero = (l_rdata0 == '0);

    // One restoring division step and one square-root step.
    assign shifted = {rem_reg[31:0], quo_reg[NUM_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, den_reg};
    assign sq_sum  = res_reg + bit_reg;

    // Multiply-accumulate of factor entries.
    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg <= $signed(l_rdata0) * $signed(l_rdata1);
        end
        if (cmd.acc_clear)
        begin
            acc_reg <= '0;
        end
        else if (cmd.acc_add)
        begin
            acc_reg <= acc_reg + (prod_reg >>> FRAC_BITS);
        end
    end

    // Iterative unit payload.
    always_ff @(posedge clk)
    begin
        if (cmd.op_start)
        begin
            diag_reg <= cmd.op_diag;
            zero_reg <= cmd.op_diag ? !diag_pos : dv_zero;
            neg_reg  <= d32[DATA_W-1] ^ l_rdata0[DATA_W-1];
            rem_reg  <= '0;
            quo_reg  <= {dmag, {FRAC_BITS{1'b0}}};
            den_reg  <= dvmag;
            v_reg    <= 64'(rad_clamp) << FRAC_BITS;
            res_reg  <= '0;
            bit_reg  <= 64'd1 << 62;
        end
        else if (busy_reg)
        begin
            if (diag_reg)
            begin
                if (v_reg >= sq_sum)
                begin
                    v_reg   <= v_reg - sq_sum;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            else
            begin
                if (!trial[33])
                begin
                    rem_reg <= trial[32:0];
                    quo_reg <= {quo_reg[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= shifted;
                    quo_reg <= {quo_reg[NUM_W-2:0], 1'b0};
                end
            end
        end
        if (cmd.out_load)
        begin
            out_reg <= cmd.out_zero ? '0 : l_rdata0;
        end
    end

    // Iterative unit control and error flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            err_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.err_clear)
            begin
                err_reg <= 1'b0;
            end
            else if (cmd.op_start && (cmd.op_diag ? !diag_pos : dv_zero))
            begin
                err_reg <= 1'b1;
            end
            if (cmd.op_start)
            begin
                busy_reg <= cmd.op_diag ? diag_pos : !dv_zero;
                cnt_reg  <= cmd.op_diag ? CNT_W'(SQ_STEP) : CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Signed, saturated result of the finished operation.
    always_comb
    begin
        if (zero_reg)
        begin
            l_wdata = '0;
        end
        else if (diag_reg)
        begin
            l_wdata = res_reg[DATA_W-1:0];
        end
        else if (!neg_reg)
        begin
            l_wdata = (quo_reg > NUM_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF
                                                        : quo_reg[DATA_W-1:0];
        end
        else
        begin
            l_wdata = (quo_reg > NUM_W'(33'h1_0000_0000 >> 1)) ? 32'h8000_0000
                                                               : (~quo_reg[DATA_W-1:0] + 32'd1);
        end
    end

    assign stat.op_done          = !busy_reg;
    assign factor_entry          = out_reg;
    assign not_positive_definite = err_reg;

endmodule

`default_nettype wire

// ===== design/cholesky_factorization.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cholesky factorization
// Loads an N by N matrix row-major, computes its lower-triangular factor in
// signed fixed point and sends all N*N factor entries row-major.
// ----------------------------------------------------------------------------
// Usage:
//   The order N is written through cfg_we/cfg_wdata while the block is idle;
//   a write drops any partially loaded matrix. Input requests are taken one
//   per cycle while loading; in_stall stays high from the last entry of a
//   matrix until its last factor entry has been taken.
//   Element (i,j), j <= i, runs a multiply-accumulate over k < j, then
//   32 square-root steps on the diagonal or 32+FRAC_BITS restoring
//   division steps below it, both run on one shared bit-serial unit.
//   Each output request passes ST_OUT_RD, ST_OUT_LOAD and ST_OUT_WAIT
//   through one registered factor-store read; with out_stall high the
//   request and its fields hold. Reset returns the order to MAX_ORDER and
//   empties the load; a factor run that hits a non-positive square-root
//   argument or a zero divisor flags not_positive_definite on all of its
//   output requests.
// ----------------------------------------------------------------------------
`default_nettype none

module cholesky_factorization #(
    parameter int MAX_ORDER = 8,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [chol_pkg::DATA_W-1:0] matrix_entry,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [chol_pkg::DATA_W-1:0]      factor_entry,
    output logic [chol_pkg::POS_W-1:0]       row_index,
    output logic [chol_pkg::POS_W-1:0]       column_index,
    output logic                             not_positive_definite,
    output logic                             last_of_run,
    input  wire logic                        cfg_we,
    input  wire logic [chol_pkg::CFG_W-1:0]  cfg_wdata
);

    import chol_pkg::*;

    localparam int IDX_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

    cmd_t               cmd;
    stat_t              stat;
    logic [2*IDX_W-1:0] a_waddr, a_raddr, l_raddr0, l_raddr1, l_waddr;

    // Sequencer.
    chol_ctrl #(.MAX_ORDER(MAX_ORDER), .IDX_W(IDX_W)) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .stat(stat), .cmd(cmd),
        .a_waddr(a_waddr), .a_raddr(a_raddr),
        .l_raddr0(l_raddr0), .l_raddr1(l_raddr1), .l_waddr(l_waddr),
        .row_index(row_index), .column_index(column_index),
        .last_of_run(last_of_run)
    );

    // Arithmetic and storage.
    chol_dp #(.FRAC_BITS(FRAC_BITS), .IDX_W(IDX_W)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .a_waddr(a_waddr), .a_raddr(a_raddr),
        .l_raddr0(l_raddr0), .l_raddr1(l_raddr1), .l_waddr(l_waddr),
        .matrix_entry(matrix_entry), .stat(stat),
        .factor_entry(factor_entry),
        .not_positive_definite(not_positive_definite)
    );

    // No input is taken while a result is pending.
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> in_stall)
        else $error("input taken while a result is pending");

    // The last result sits on the diagonal.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_of_run) |-> (row_index == column_index))
        else $error("last result off the diagonal");

    // Entries above the diagonal are zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (column_index > row_index)) |-> (factor_entry == '0))
        else $error("nonzero entry above the diagonal");

endmodule

`default_nettype wire

// ===== sim/cholesky_factorization_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cholesky factorization checker
// Watches the matrix entries and order writes going into the block. It
// rebuilds each loaded matrix and works out its fixed-point factor. Every
// factor request that leaves the block is compared against the oldest
// predicted entry.
// ----------------------------------------------------------------------------

module cholesky_factorization_checker #(
    parameter int MAX_ORDER = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic [chol_pkg::DATA_W-1:0] matrix_entry,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [chol_pkg::DATA_W-1:0] factor_entry,
    input  logic [chol_pkg::POS_W-1:0]  row_index,
    input  logic [chol_pkg::POS_W-1:0]  column_index,
    input  logic                        not_positive_definite,
    input  logic                        last_of_run,
    input  logic                        cfg_we,
    input  logic [chol_pkg::CFG_W-1:0]  cfg_wdata,
    output int                          mismatch_count,
    output int                          factors_pending
);

    typedef struct {
        logic [chol_pkg::DATA_W-1:0] entry;
        logic [chol_pkg::POS_W-1:0]  row;
        logic [chol_pkg::POS_W-1:0]  col;
        logic                        npd;
        logic                        last;
    } factor_req_t;

    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;

    factor_req_t                 pending_factors[$];
    longint                      loaded_matrix[MAX_ORDER*MAX_ORDER];
    logic [chol_pkg::CFG_W-1:0]  order_reg;
    int                          entries_loaded;

    function automatic longint clamp32(longint v);
        if (v > SAT_HI)
            return SAT_HI;
        if (v < SAT_LO)
            return SAT_LO;
        return v;
    endfunction

    // Arithmetic shift of the exact product rounds toward minus infinity.
    function automatic longint fx_product(longint a, longint b);
        return (a * b) >>> FRAC_BITS;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned probe;
        root = 0;
        probe = 64'd1 << 62;
        while (probe > v)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (v >= root + probe)
            begin
                v = v - (root + probe);
                root = (root >> 1) + probe;
            end
            else
                root = root >> 1;
            probe = probe >> 2;
        end
        return root;
    endfunction

    function automatic int active_order();
        if (order_reg == 0)
            return 1;
        if (order_reg > MAX_ORDER)
            return MAX_ORDER;
        return order_reg;
    endfunction

    // Factor the loaded matrix and queue all N*N output requests.
    task automatic factor_matrix(input int n);
        longint      fac[MAX_ORDER][MAX_ORDER];
        longint      acc;
        longint      diff;
        longint      sq;
        longint      residue;
        bit          err;
        factor_req_t req;
        err = 0;
        for (int i = 0; i < n; i++)
        begin
            sq = 0;
            for (int j = 0; j < n; j++)
            begin
                if (i > j)
                begin
                    acc = 0;
                    for (int k = 0; k < j; k++)
                        acc += fx_product(fac[j][k], fac[i][k]);
                    diff = clamp32(loaded_matrix[j*n + i] - acc);
                    if (fac[j][j] == 0)
                    begin
                        fac[i][j] = 0;
                        err = 1;
                    end
                    else
                        fac[i][j] = clamp32((diff * (64'sd1 << FRAC_BITS)) / fac[j][j]);
                    sq += fx_product(fac[i][j], fac[i][j]);
                end
                else if (i == j)
                begin
                    residue = loaded_matrix[i*n + i] - sq;
                    if (residue <= 0)
                    begin
                        fac[i][i] = 0;
                        err = 1;
                    end
                    else
                    begin
                        if (residue > SAT_HI)
                            residue = SAT_HI;
                        fac[i][i] = longint'(int_sqrt(longint'(residue) << FRAC_BITS));
                    end
                end
                else
                    fac[i][j] = 0;
            end
        end
        for (int i = 0; i < n; i++)
        begin
            for (int j = 0; j < n; j++)
            begin
                req.entry = fac[i][j][31:0];
                req.row   = i[2:0];
                req.col   = j[2:0];
                req.npd   = err;
                req.last  = (i == n - 1) && (j == n - 1);
                pending_factors.push_back(req);
            end
        end
    endtask

    // Track loads and order writes, and check each accepted factor request.
    always @(posedge clk or negedge rst_n)
    begin
        factor_req_t want;
        int          n;
        if (!rst_n)
        begin
            pending_factors.delete();
            order_reg       <= MAX_ORDER;
            entries_loaded  = 0;
            mismatch_count  <= 0;
            factors_pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                order_reg <= cfg_wdata;
                entries_loaded = 0;
            end
            if (in_valid && !in_stall)
            begin
                n = active_order();
                loaded_matrix[entries_loaded] = longint'($signed(matrix_entry));
                entries_loaded++;
                if (entries_loaded >= n * n)
                begin
                    entries_loaded = 0;
                    factor_matrix(n);
                end
            end
            if (out_valid && !out_stall)
            begin
                if (pending_factors.size() == 0)
                begin
                    $error("factor request with no prediction waiting");
                    mismatch_count <= mismatch_count + 1;
                end
                else
                begin
                    want = pending_factors.pop_front();
                    if (factor_entry !== want.entry || row_index !== want.row
                        || column_index !== want.col
                        || not_positive_definite !== want.npd
                        || last_of_run !== want.last)
                        mismatch_count <= mismatch_count + 1;
                    if (factor_entry !== want.entry)
                        $error("factor_entry: expected %h, actual %h", want.entry,
                               factor_entry);
                    if (row_index !== want.row)
                        $error("row_index: expected %0d, actual %0d", want.row, row_index);
                    if (column_index !== want.col)
                        $error("column_index: expected %0d, actual %0d", want.col,
                               column_index);
                    if (not_positive_definite !== want.npd)
                        $error("not_positive_definite: expected %b, actual %b", want.npd,
                               not_positive_definite);
                    if (last_of_run !== want.last)
                        $error("last_of_run: expected %b, actual %b", want.last,
                               last_of_run);
                end
            end
            factors_pending <= pending_factors.size();
        end
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cholesky factorization testbench
// Drives matrices of every order through the block. It starts with corner
// matrices, then moves to mostly positive-definite random matrices mixed with
// noise and broken diagonals. Both sides idle at random while a separate
// checker compares every factor request.
// ----------------------------------------------------------------------------

module tb;

    localparam int MAX_ORDER = 8;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_stall;
    logic [chol_pkg::DATA_W-1:0] matrix_entry;
    logic                        out_valid;
    logic                        out_stall;
    logic [chol_pkg::DATA_W-1:0] factor_entry;
    logic [chol_pkg::POS_W-1:0]  row_index;
    logic [chol_pkg::POS_W-1:0]  column_index;
    logic                        not_positive_definite;
    logic                        last_of_run;
    logic                        cfg_we;
    logic [chol_pkg::CFG_W-1:0]  cfg_wdata;
    int                          mismatch_count;
    int                          factors_pending;

    int sender_idle_pct;
    int receiver_stall_pct;
    int hold_left;
    int order_now;
    int random_entries;

    cholesky_factorization #(.MAX_ORDER(MAX_ORDER), .FRAC_BITS(16)) uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .matrix_entry(matrix_entry),
        .out_valid(out_valid), .out_stall(out_stall), .factor_entry(factor_entry),
        .row_index(row_index), .column_index(column_index),
        .not_positive_definite(not_positive_definite), .last_of_run(last_of_run),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    cholesky_factorization_checker #(.MAX_ORDER(MAX_ORDER), .FRAC_BITS(16)) u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .matrix_entry(matrix_entry),
        .out_valid(out_valid), .out_stall(out_stall), .factor_entry(factor_entry),
        .row_index(row_index), .column_index(column_index),
        .not_positive_definite(not_positive_definite), .last_of_run(last_of_run),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .mismatch_count(mismatch_count), .factors_pending(factors_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Run limit, far above the slowest passing run.
    initial
    begin
        #40_000_000;
        $display("cholesky_factorization regression: fail");
        $finish;
    end

    // Receiver: random stalls, or a long hold when one is requested.
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    // Offer one entry, with an occasional idle gap first, and wait for it.
    task automatic send_entry(input logic [31:0] value);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        matrix_entry <= value;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Order write, made only once every predicted request has been taken.
    task automatic write_order(input logic [3:0] value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (factors_pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (value == 0)
            order_now = 1;
        else if (value > MAX_ORDER)
            order_now = MAX_ORDER;
        else
            order_now = value;
    endtask

    // Build one matrix of the current order and send it row-major.
    // Kinds: 0 diagonally dominant, 1 raw noise, 2 dominant with a bad pivot.
    task automatic send_matrix(input int kind);
        logic [31:0] a[MAX_ORDER][MAX_ORDER];
        int          bad;
        int          n;
        n = order_now;
        for (int i = 0; i < n; i++)
        begin
            for (int j = i; j < n; j++)
            begin
                if (kind == 1)
                    a[i][j] = $urandom;
                else if (i == j)
                    a[i][j] = ($urandom_range(n * 64 + 2000, n * 64 + 1) << 16)
                              | $urandom_range(16'hFFFF);
                else
                    a[i][j] = $urandom_range(64 << 16) - (32 << 16);
                a[j][i] = (kind == 1) ? $urandom : a[i][j];
            end
        end
        if (kind == 2)
        begin
            bad = $urandom_range(n - 1);
            a[bad][bad] = ($urandom_range(1)) ? 32'd0 : -($urandom_range(1 << 20));
        end
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
                send_entry(a[i][j]);
    endtask

    // Stimulus.
    initial
    begin
        int          pick;
        logic [3:0]  size_code;
        rst_n              <= 1'b0;
        in_valid           <= 1'b0;
        matrix_entry       <= '0;
        cfg_we             <= 1'b0;
        cfg_wdata          <= '0;
        sender_idle_pct    = 24;
        receiver_stall_pct = 85;
        hold_left          = 0;
        order_now          = MAX_ORDER;
        random_entries     = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Order one: the field extremes, zero and one.
        write_order(4'd1);
        send_entry(32'h7FFF_FFFF);
        send_entry(32'h8000_0000);
        send_entry(32'h0000_0000);
        send_entry(32'h0001_0000);

        // Order two: zero pivot with a zero divisor, saturating quotient,
        // negative diagonal.
        write_order(4'd2);
        send_entry(32'h0000_0000);
        send_entry(32'h0005_0000);
        send_entry(32'h0005_0000);
        send_entry(32'h0001_0000);
        send_entry(32'h0000_0001);
        send_entry(32'h7FFF_FFFF);
        send_entry(32'h8000_0000);
        send_entry(32'h7FFF_FFFF);
        send_entry(32'hFFFF_0000);
        send_entry(32'h0000_0000);
        send_entry(32'h0000_0000);
        send_entry(32'hFFFF_FFFF);

        // An order of zero acts as order one.
        write_order(4'd0);
        send_entry(32'h0004_0000);

        // A partial load is dropped by an order write.
        write_order(4'd3);
        repeat (4) send_entry($urandom);
        write_order(4'd2);
        send_matrix(0);

        // Random matrices across three idle profiles.
        hold_left = 3000;
        while (random_entries < 200)
        begin
            if (random_entries >= 134)
            begin
                sender_idle_pct    = 0;
                receiver_stall_pct = 0;
            end
            else if (random_entries >= 67)
            begin
                sender_idle_pct    = 85;
                receiver_stall_pct = 24;
            end
            if ($urandom_range(1) == 1)
            begin
                pick = $urandom_range(99);
                if (pick < 10)
                    size_code = (pick < 3) ? 4'd0 : 4'($urandom_range(15, 9));
                else if (pick < 80)
                    size_code = 4'($urandom_range(4, 1));
                else
                    size_code = 4'($urandom_range(8, 5));
                write_order(size_code);
            end
            pick = $urandom_range(99);
            send_matrix((pick < 70) ? 0 : (pick < 85) ? 1 : 2);
            random_entries += order_now * order_now;
        end

        // Drain and settle.
        in_valid <= 1'b0;
        @(posedge clk);
        while (factors_pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatch_count == 0 && factors_pending == 0)
            $display("cholesky_factorization regression: pass");
        else
            $display("cholesky_factorization regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
design/chol_pkg.sv
design/chol_ram.sv
design/chol_ctrl.sv
design/chol_dp.sv
design/cholesky_factorization.sv
sim/cholesky_factorization_checker.sv
sim/tb.sv
